// ===== rtl/sssg_pkg.sv =====
// Shared types, constants and the segment decode table for the frame builder.
`timescale 1ns / 1ps

package sssg_pkg;

   localparam int NUM_DIGITS  = 16;
   localparam int HALF_DIGITS = 8;
   localparam int SEG_BITS    = 8;
   localparam int POINT_DIGIT = 3;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_SHOW  = 2'd1;
   localparam logic [1:0] OP_LEDS  = 2'd2;

   localparam logic [7:0] CMD_BRIGHT  = 8'h8F;
   localparam logic [7:0] CMD_AUTOINC = 8'h40;
   localparam logic [7:0] CMD_FIXED   = 8'h44;
   localparam logic [7:0] CMD_ADDR    = 8'hC0;
   localparam logic [7:0] SEG_POINT   = 8'h80;

   typedef logic [NUM_DIGITS-1:0][SEG_BITS-1:0] seg_array_type;
   typedef logic [NUM_DIGITS-1:0][7:0]          frame_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       last;
   } beat_type;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_BRIGHT  = 8'b0000_0010,
      ST_AUTOINC = 8'b0000_0100,
      ST_BASE    = 8'b0000_1000,
      ST_ZERO    = 8'b0001_0000,
      ST_FIXED   = 8'b0010_0000,
      ST_ADDR    = 8'b0100_0000,
      ST_DATA    = 8'b1000_0000
   } state_type;

   function automatic logic [SEG_BITS-1:0] seg_decode(input logic [3:0] digit);
      logic [SEG_BITS-1:0] seg;
      unique case (digit)
         4'h0: seg = 8'h3F;
         4'h1: seg = 8'h06;
         4'h2: seg = 8'h5B;
         4'h3: seg = 8'h4F;
         4'h4: seg = 8'h66;
         4'h5: seg = 8'h6D;
         4'h6: seg = 8'h7D;
         4'h7: seg = 8'h07;
         4'h8: seg = 8'h7F;
         4'h9: seg = 8'h6F;
         4'hA: seg = 8'h77;
         4'hB: seg = 8'h7C;
         4'hC: seg = 8'h39;
         4'hD: seg = 8'h5E;
         4'hE: seg = 8'h79;
         4'hF: seg = 8'h71;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

// ===== rtl/sssg_if.sv =====
// Valid/ready channel interfaces for commands and transmit bytes.
`timescale 1ns / 1ps

interface sssg_req_bus;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [63:0] digits;
   logic        point_on;
   logic [7:0]  led_mask;

   modport source (output valid, operation, digits, point_on, led_mask, input ready);
   modport sink   (input valid, operation, digits, point_on, led_mask, output ready);
endinterface

interface sssg_rsp_bus;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_end;
   logic       last;

   modport source (output valid, tx_byte, frame_end, last, input ready);
   modport sink   (input valid, tx_byte, frame_end, last, output ready);
endinterface

// ===== rtl/sssg_digit_lane.sv =====
// One digit lane: hex to seven-segment decode with optional decimal point.
`timescale 1ns / 1ps

module sssg_digit_lane
   import sssg_pkg::*;
(
   input  logic [3:0]          digit,
   input  logic                point_en,
   output logic [SEG_BITS-1:0] seg
);

   assign seg = seg_decode(digit) | (point_en ? SEG_POINT : '0);

endmodule

// ===== rtl/sssg_merge.sv =====
// Merge of the lane outputs: transpose each half into per-segment data bytes.
`timescale 1ns / 1ps

module sssg_merge
   import sssg_pkg::*;
(
   input  seg_array_type seg,
   input  logic [1:0]    operation,
   input  logic [7:0]    led_mask,
   output frame_type     frame
);

   always_comb begin
      for (int j = 0; j < HALF_DIGITS; j++) begin
         for (int i = 0; i < HALF_DIGITS; i++) begin
            frame[j][i]               = seg[i][j];
            frame[HALF_DIGITS + j][i] = seg[HALF_DIGITS + i][j];
         end
      end
      // LED writes reuse the odd-address slots of the upper half
      if (operation == OP_LEDS) begin
         for (int k = 0; k < HALF_DIGITS; k++) begin
            frame[HALF_DIGITS + k] = {7'b0, led_mask[k]};
         end
      end
   end

endmodule

// ===== rtl/sssg_sequencer.sv =====
// Command holding register and byte sequencer with registered output beat.
`timescale 1ns / 1ps

module sssg_sequencer
   import sssg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  frame_type  req_frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output beat_type   rsp_beat
);

   logic       cap_valid_ff, cap_valid_in;
   logic [1:0] cap_op_ff;
   frame_type  cap_frame_ff;

   state_type  state_ff, state_in, state_nxt;
   logic [3:0] w_ff, w_in, w_nxt;
   frame_type  frame_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   beat_type   beat_ff, beat_in, beat;

   logic emit, final_beat, out_free, take_cap, req_fire, op_known;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      beat       = '0;
      emit       = 1'b0;
      final_beat = 1'b0;
      state_nxt  = state_ff;
      w_nxt      = w_ff;
      unique case (state_ff)
         ST_IDLE: begin
            state_nxt = ST_IDLE;
         end
         ST_BRIGHT: begin
            emit      = 1'b1;
            beat      = '{tx_byte: CMD_BRIGHT, frame_end: 1'b1, last: 1'b0};
            state_nxt = ST_AUTOINC;
         end
         ST_AUTOINC: begin
            emit      = 1'b1;
            beat      = '{tx_byte: CMD_AUTOINC, frame_end: 1'b1, last: 1'b0};
            state_nxt = ST_BASE;
         end
         ST_BASE: begin
            emit      = 1'b1;
            beat      = '{tx_byte: CMD_ADDR, frame_end: 1'b0, last: 1'b0};
            state_nxt = ST_ZERO;
            w_nxt     = '0;
         end
         ST_ZERO: begin
            emit       = 1'b1;
            final_beat = (w_ff == 4'hF);
            beat       = '{tx_byte: 8'h00, frame_end: final_beat, last: final_beat};
            w_nxt      = w_ff + 4'd1;
         end
         ST_FIXED: begin
            emit      = 1'b1;
            beat      = '{tx_byte: CMD_FIXED, frame_end: 1'b1, last: 1'b0};
            state_nxt = ST_ADDR;
         end
         ST_ADDR: begin
            emit      = 1'b1;
            // lower half to even addresses, upper half to odd ones
            beat      = '{tx_byte: CMD_ADDR | {4'b0, w_ff[2:0], w_ff[3]},
                          frame_end: 1'b0, last: 1'b0};
            state_nxt = ST_DATA;
         end
         ST_DATA: begin
            emit       = 1'b1;
            final_beat = (w_ff == 4'hF);
            beat       = '{tx_byte: frame_ff[w_ff], frame_end: 1'b1, last: final_beat};
            state_nxt  = ST_FIXED;
            w_nxt      = w_ff + 4'd1;
         end
         default: begin
            state_nxt = ST_IDLE;
         end
      endcase
   end

   assign take_cap  = cap_valid_ff && (state_ff == ST_IDLE || (final_beat && out_free));
   assign req_ready = !cap_valid_ff || take_cap;
   assign req_fire  = req_valid && req_ready;
   assign op_known  = (req_op == OP_CLEAR) || (req_op == OP_SHOW) || (req_op == OP_LEDS);

   always_comb begin
      // drop unknown operations at the holding register
      cap_valid_in = (cap_valid_ff && !take_cap) || (req_fire && op_known);
      state_in     = state_ff;
      w_in         = w_ff;
      if (take_cap) begin
         priority if (cap_op_ff == OP_CLEAR) begin
            state_in = ST_BRIGHT;
            w_in     = '0;
         end else if (cap_op_ff == OP_SHOW) begin
            state_in = ST_FIXED;
            w_in     = '0;
         end else begin
            state_in = ST_FIXED;
            w_in     = 4'd8;
         end
      end else if (emit && out_free) begin
         state_in = final_beat ? ST_IDLE : state_nxt;
         w_in     = w_nxt;
      end else if (state_ff != ST_IDLE && !emit) begin
         state_in = state_nxt;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      beat_in      = beat_ff;
      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
         beat_in      = beat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_valid_ff <= cap_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      beat_ff <= beat_in;
      if (req_fire) begin
         cap_op_ff    <= req_op;
         cap_frame_ff <= req_frame;
      end
      if (take_cap) begin
         frame_ff <= cap_frame_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

// ===== rtl/seven_segment_grid_frame_builder_core.sv =====
// Top level of the seven-segment grid frame builder.
`timescale 1ns / 1ps

// Takes one display command per beat on req_bus and sends the controller bytes on
// rsp_bus, one byte per cycle while the sink is ready. Clear gives 19 bytes, show
// digits 48 and set LEDs 24; last marks the final byte of a command and frame_end
// marks where strobe is released. Sixteen decode lanes and a transpose merge turn a
// command into its data bytes in the accept cycle; a one-entry holding register then
// lets the next command be accepted while the current one is still being sent, so
// commands follow each other back to back while the sink is ready, and the rate is
// set by the byte sequencer. Operation code 3 is accepted and dropped.
module seven_segment_grid_frame_builder_core
   import sssg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sssg_req_bus.sink   req_bus,
   sssg_rsp_bus.source rsp_bus
);

   seg_array_type seg;
   frame_type     frame;
   beat_type      beat;

   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_lane
      sssg_digit_lane u_lane (
         .digit    (req_bus.digits[4*k +: 4]),
         .point_en ((k == POINT_DIGIT) ? req_bus.point_on : 1'b0),
         .seg      (seg[k])
      );
   end

   sssg_merge u_merge (
      .seg       (seg),
      .operation (req_bus.operation),
      .led_mask  (req_bus.led_mask),
      .frame     (frame)
   );

   sssg_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_op    (req_bus.operation),
      .req_frame (frame),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_beat  (beat)
   );

   assign rsp_bus.tx_byte   = beat.tx_byte;
   assign rsp_bus.frame_end = beat.frame_end;
   assign rsp_bus.last      = beat.last;

endmodule
